[hw/rtl/xbc_pkg.sv]
`timescale 1ns / 1ps

package xbc_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_KEYS = 4;
	localparam int KIDX_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	typedef struct packed {
		logic              func;
		logic [WORD_W-1:0] block_lo;
		logic [WORD_W-1:0] block_hi;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_lo;
		logic [WORD_W-1:0] result_hi;
	} out_item_t;

	typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
		mix = ((v << 4) ^ (v >> 5)) + v;
	endfunction

endpackage

[hw/rtl/xbc_stage.sv]
`timescale 1ns / 1ps

// One half-round. The sum schedule is fixed per stage, so only the direction
// picks between two elaboration-time constants.
module xbc_stage import xbc_pkg::*; #(
	parameter int ROUNDS = 32,
	parameter int STAGE  = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  key_set_t key,
	input  logic     in_vld,
	input  in_item_t in_blk,
	output logic     vld_s1,
	output in_item_t blk_s1
);

	localparam int RND = STAGE / 2;
	localparam bit ODD = (STAGE % 2) == 1;
	localparam int ENC_MULT = ODD ? RND + 1 : RND;
	localparam int DEC_MULT = ODD ? ROUNDS - RND - 1 : ROUNDS - RND;

	localparam logic [63:0] ENC_PROD = 64'(DELTA) * 64'(ENC_MULT);
	localparam logic [63:0] DEC_PROD = 64'(DELTA) * 64'(DEC_MULT);
	localparam logic [WORD_W-1:0] SUM_ENC = ENC_PROD[WORD_W-1:0];
	localparam logic [WORD_W-1:0] SUM_DEC = DEC_PROD[WORD_W-1:0];

	// first half of a round keys on sum[1:0] when encrypting, sum[12:11] when decrypting
	localparam logic [KIDX_W-1:0] KEY_ENC = ODD ? SUM_ENC[12:11] : SUM_ENC[1:0];
	localparam logic [KIDX_W-1:0] KEY_DEC = ODD ? SUM_DEC[1:0] : SUM_DEC[12:11];

	logic              dec;
	logic              upd_lo;
	logic [WORD_W-1:0] sum;
	logic [KIDX_W-1:0] kidx;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] tmix;
	logic [WORD_W-1:0] nv;

	always_comb begin
		dec    = (in_blk.func == FUNC_DECRYPT);
		sum    = dec ? SUM_DEC : SUM_ENC;
		kidx   = dec ? KEY_DEC : KEY_ENC;
		upd_lo = ODD ? dec : !dec;
		src    = upd_lo ? in_blk.block_hi : in_blk.block_lo;
		dst    = upd_lo ? in_blk.block_lo : in_blk.block_hi;
		tmix   = mix(src) ^ (sum + key[kidx]);
		nv     = dec ? dst - tmix : dst + tmix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		blk_s1.func     <= in_blk.func;
		blk_s1.block_lo <= upd_lo ? nv : in_blk.block_lo;
		blk_s1.block_hi <= upd_lo ? in_blk.block_hi : nv;
	end

endmodule

[hw/rtl/xtea_block_cipher.sv]
`timescale 1ns / 1ps

// XTEA cipher, 64-bit block, 128-bit key, fully pipelined: every half-round
// has its own register stage, 2*ROUNDS stages in all (64 at the default of
// 32 rounds). A block is taken on every cycle that start is high, busy never
// rises, and each result appears on result with done high for one cycle
// once it has passed the last stage register; the sink has no way to hold
// it, so it must take every beat. Key words are written through cfg_we,
// cfg_index and cfg_data and must only change while no block is in flight.
module xtea_block_cipher import xbc_pkg::*; #(
	parameter int ROUNDS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             blk,
	output logic                 done,
	output out_item_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	localparam int NSTG = 2 * ROUNDS;

	key_set_t key_q;
	logic     vld_c [NSTG+1];
	in_item_t blk_c [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_WORD_0: key_q[0] <= cfg_data;
				REG_KEY_WORD_1: key_q[1] <= cfg_data;
				REG_KEY_WORD_2: key_q[2] <= cfg_data;
				REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy     = 1'b0;
	assign vld_c[0] = start && !busy;
	assign blk_c[0] = blk;

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		xbc_stage #(
			.ROUNDS(ROUNDS),
			.STAGE (g)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.key   (key_q),
			.in_vld(vld_c[g]),
			.in_blk(blk_c[g]),
			.vld_s1(vld_c[g+1]),
			.blk_s1(blk_c[g+1])
		);
	end

	assign done             = vld_c[NSTG];
	assign result.result_lo = blk_c[NSTG].block_lo;
	assign result.result_hi = blk_c[NSTG].block_hi;

endmodule

[tb/sv/tb_xtea_block_cipher.sv]
`timescale 1ns / 1ps

module tb_xtea_block_cipher;
	import xbc_pkg::*;

	localparam int N_ROUNDS    = 32;
	localparam int LATENCY     = 2 * N_ROUNDS;
	localparam int QUIET_LIMIT = 2000;
	localparam int N_CORNERS   = 12;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 260;
	localparam int SHOW_MAX    = 10;

	localparam logic [CFG_IDX_W-1:0] KEY_REG [NUM_KEYS] = '{
		REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3
	};

	// corner blocks, run once with the reset key and once with an all-ones key
	localparam in_item_t CORNER_BLOCKS [N_CORNERS] = '{
		'{FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
		'{FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000},
		'{FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff},
		'{FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff},
		'{FUNC_ENCRYPT, 32'hffff_ffff, 32'h0000_0000},
		'{FUNC_ENCRYPT, 32'h0000_0000, 32'hffff_ffff},
		'{FUNC_DECRYPT, 32'hffff_ffff, 32'h0000_0000},
		'{FUNC_DECRYPT, 32'h0000_0000, 32'hffff_ffff},
		'{FUNC_ENCRYPT, 32'h0000_0001, 32'h8000_0000},
		'{FUNC_DECRYPT, 32'h8000_0000, 32'h0000_0001},
		'{FUNC_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef},
		'{FUNC_DECRYPT, 32'h0123_4567, 32'h89ab_cdef}
	};

	typedef struct {
		out_item_t res;
		logic      func;
	} cipher_beat_t;

	typedef struct {
		out_item_t res;
		logic      func;
		bit        ok;
	} chain_src_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  blk = '0;
	logic      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_WORD_0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	key_set_t     key_copy = '0;
	cipher_beat_t cipher_q [$];
	cipher_beat_t head;
	chain_src_t   chain_src = '{res: '0, func: 1'b0, ok: 1'b0};
	int           bad_beats = 0;
	int           quiet = 0;

	xtea_block_cipher #(.ROUNDS(N_ROUNDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.blk       (blk),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		t = (v << 4) ^ (v >> 5);
		return t + v;
	endfunction

	function automatic out_item_t xtea_expected(input in_item_t b);
		logic [WORD_W-1:0] v0, v1, s;
		out_item_t o;
		v0 = b.block_lo;
		v1 = b.block_hi;
		if (b.func == FUNC_DECRYPT) begin
			s = DELTA * N_ROUNDS;
			for (int r = 0; r < N_ROUNDS; r++) begin
				v1 = v1 - (round_f(v0) ^ (s + key_copy[s[12:11]]));
				s  = s - DELTA;
				v0 = v0 - (round_f(v1) ^ (s + key_copy[s[1:0]]));
			end
		end else begin
			s = '0;
			for (int r = 0; r < N_ROUNDS; r++) begin
				v0 = v0 + (round_f(v1) ^ (s + key_copy[s[1:0]]));
				s  = s + DELTA;
				v1 = v1 + (round_f(v0) ^ (s + key_copy[s[12:11]]));
			end
		end
		o.result_lo = v0;
		o.result_hi = v1;
		return o;
	endfunction

	// mostly random words, with all-zero, all-ones and one-hot thrown in
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_block(input in_item_t b, input bit gaps);
		while (gaps && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		blk   <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cipher_q.push_back('{res: xtea_expected(b), func: b.func});
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic load_key(input key_set_t k);
		drain_pipe();
		for (int j = 0; j < NUM_KEYS; j++) begin
			cfg_we    <= 1'b1;
			cfg_index <= KEY_REG[j];
			cfg_data  <= k[j];
			@(posedge clk);
			key_copy[KEY_REG[j]] = k[j];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		bad_beats++;
		if (bad_beats <= SHOW_MAX)
			$display("%t mismatch %s: expected %h got %h", $realtime, name, want, got);
	endtask

	// result checker; done is sampled as it stood before the edge
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (cipher_q.size() == 0) begin
				bad_beats++;
				if (bad_beats <= SHOW_MAX)
					$display("%t unexpected result beat %h", $realtime, result);
			end else begin
				head = cipher_q.pop_front();
				if (result.result_lo !== head.res.result_lo)
					report_field("result_lo", head.res.result_lo, result.result_lo);
				if (result.result_hi !== head.res.result_hi)
					report_field("result_hi", head.res.result_hi, result.result_hi);
				chain_src <= '{res: result, func: head.func, ok: 1'b1};
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		key_set_t  phase_key [N_PHASES];
		bit        gaps;
		in_item_t  b;

		phase_key[0] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
		phase_key[1] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
		phase_key[2] = '{32'h7654_3210, 32'hfedc_ba98, 32'h89ab_cdef, 32'h0123_4567};
		phase_key[3] = '{$urandom, $urandom, $urandom, $urandom};
		phase_key[4] = '{$urandom, $urandom, $urandom, $urandom};
		phase_key[5] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners under the reset key
		for (int i = 0; i < N_CORNERS; i++)
			push_block(CORNER_BLOCKS[i], 1'b1);

		for (int p = 0; p < N_PHASES; p++) begin
			load_key(phase_key[p]);
			if (p == 0) begin
				for (int i = 0; i < N_CORNERS; i++)
					push_block(CORNER_BLOCKS[i], 1'b1);
			end
			gaps = (p != 1);	// back-to-back beats for a whole phase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (chain_src.ok && $urandom_range(3) == 0) begin
					// feed a finished block back the other way
					b.func     = ~chain_src.func;
					b.block_lo = chain_src.res.result_lo;
					b.block_hi = chain_src.res.result_hi;
				end else begin
					b.func     = $urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
					b.block_lo = pick_word();
					b.block_hi = pick_word();
				end
				push_block(b, gaps);
			end
		end

		drain_pipe();
		if (bad_beats == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
